FILE: design/multi_stack_shared_pool_assert.svh
// Assertion macros used by the stack pool module.
// With SYNTH defined every macro expands to nothing.
`ifndef MULTI_STACK_SHARED_POOL_ASSERT_SVH
`define MULTI_STACK_SHARED_POOL_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication: when ante holds, cons holds in that cycle.
`define MSSP_ASSERT_NOW(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication: when ante holds, cons holds in the cycle after.
`define MSSP_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MSSP_ASSERT_NOW(lbl, clk_i, rst_i, ante, cons)
`define MSSP_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons)
`endif
`endif

FILE: design/mssp_pkg.sv
package mssp_pkg;

  localparam int NUM_STACKS_DEF = 8;
  localparam int POOL_DEPTH_DEF = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the item formats.
  localparam int SID_FIELD_W = 3;
  localparam int VAL_FIELD_W = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE
  } state_t;

endpackage

FILE: design/multi_stack_shared_pool.sv
// Channel   Dir  tdata                          tuser
// s_*       in   [2:0] stack_id, [34:3] push_value   [0] mode (0 push, 1 pop)
// m_*       out  [31:0] pop_value               [1:0] status (0 done, 1 full, 2 empty)
//
// In steady state the accept cycle of an item reads the stack head memory, the next
// cycle reads the link and data memories at the chosen slot, and the write-back cycle
// updates the memories while the next item is already accepted. The result register
// on m_* is loaded at write-back, after the read cycle. Reset is synchronous and needs
// no clearing pass: a fill mark stands in for the initial free chain. A stalled result
// holds the write-back cycle and thereby the input side.
`include "multi_stack_shared_pool_assert.svh"

module multi_stack_shared_pool
  import mssp_pkg::*;
#(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] stack_id, [34:3] push_value
  input  logic                   s_tuser,   // [0] mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] pop_value
  output logic [1:0]             m_tuser    // [1:0] status
);

  // Slot pointers carry one extra code, POOL_DEPTH, that stands for null.
  localparam int PTR_W = $clog2(POOL_DEPTH + 1);
  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int SID_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PTR_W-1:0] LINK_NULL = PTR_W'(POOL_DEPTH);
  localparam logic [6:0] NUM_STACKS_V = 7'(NUM_STACKS);

  function automatic logic [PTR_W-1:0] clean_link(input logic [PTR_W-1:0] v);
    return (v < LINK_NULL) ? v : LINK_NULL;
  endfunction

  // Memories: data and links per slot, and the top slot of each stack.
  logic [DATA_WIDTH-1:0] data_mem [POOL_DEPTH];
  logic [PTR_W-1:0]      link_mem [POOL_DEPTH];
  logic [PTR_W-1:0]      head_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] head_vld;

  state_t state, state_next;

  // Item registers, held from accept through write-back.
  mode_t                 mode_q;
  logic [SID_FIELD_W-1:0] sid_q;
  logic [DATA_WIDTH-1:0] val_q;

  // Head read and its bypass from a write-back in the accept cycle.
  logic [PTR_W-1:0] head_rd;
  logic             fwd;
  logic [PTR_W-1:0] fwd_val;

  // Registered decisions of the read cycle.
  logic [PTR_W-1:0]      slot_q;
  logic [PTR_W-1:0]      head_b_q;
  logic                  virt_q;
  status_t               st_q;
  logic [PTR_W-1:0]      link_rd;
  logic [DATA_WIDTH-1:0] data_rd;

  // Pool bookkeeping: free list head and fill mark. Slots at or above the mark
  // were never written and still link to their successor.
  logic [PTR_W-1:0] free_head;
  logic [PTR_W-1:0] hwm;

  logic                   accept;
  logic                   out_free;
  logic                   commit;
  logic                   wr_en;
  logic [SID_FIELD_W-1:0] sid_in;
  logic [SID_W-1:0]       sid_in_idx;
  logic [SID_W-1:0]       sid_idx;
  logic                   sid_ok;
  logic [PTR_W-1:0]       head_cur;
  logic [PTR_W-1:0]       head_b;
  logic [PTR_W-1:0]       slot_b;
  logic                   virt_b;
  status_t                st_b;
  logic [IDX_W-1:0]       slot_b_idx;
  logic [IDX_W-1:0]       slot_idx;
  logic [PTR_W-1:0]       link_val;
  logic [PTR_W-1:0]       slot_inc;
  logic [PTR_W-1:0]       link_wdata;
  logic [PTR_W-1:0]       head_wdata;

  assign sid_in     = s_tdata[SID_FIELD_W-1:0];
  assign sid_in_idx = SID_W'(sid_in);
  assign sid_idx    = SID_W'(sid_q);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign commit     = (state == S_WRITE) && out_free;
  assign wr_en      = commit && (st_q == ST_DONE);

  // Control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        s_tready = out_free;
        if (out_free) begin
          state_next = s_tvalid ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Item capture and head read. The write-back of the item before may hit the
  // same stack in this very cycle, so its head value is bypassed.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode_t'(s_tuser);
      sid_q   <= sid_in;
      val_q   <= DATA_WIDTH'($unsigned(s_tdata[SID_FIELD_W +: VAL_FIELD_W]));
      head_rd <= head_mem[sid_in_idx];
      fwd     <= wr_en && (sid_idx == sid_in_idx);
      fwd_val <= head_wdata;
    end
  end

  // Read cycle: pick the slot and decide the outcome.
  always_comb begin
    sid_ok   = ({4'b0000, sid_q} < NUM_STACKS_V);
    head_cur = fwd ? fwd_val : head_rd;
    head_b   = head_vld[sid_idx] ? clean_link(head_cur) : LINK_NULL;
    slot_b   = (mode_q == MODE_POP) ? head_b : free_head;
    virt_b   = (slot_b >= hwm);
    if (mode_q == MODE_POP) begin
      st_b = (!sid_ok || (head_b == LINK_NULL)) ? ST_EMPTY : ST_DONE;
    end else begin
      st_b = (!sid_ok || (free_head == LINK_NULL)) ? ST_FULL : ST_DONE;
    end
  end

  assign slot_b_idx = slot_b[IDX_W-1:0];
  assign slot_idx   = slot_q[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      slot_q   <= slot_b;
      head_b_q <= head_b;
      virt_q   <= virt_b;
      st_q     <= st_b;
    end
  end

  // Write-back cycle values.
  assign slot_inc   = slot_q + PTR_W'(1);
  assign link_val   = virt_q ? slot_inc : clean_link(link_rd);
  assign link_wdata = (mode_q == MODE_PUSH) ? head_b_q : free_head;
  assign head_wdata = (mode_q == MODE_PUSH) ? slot_q : link_val;

  // Slot data memory.
  always_ff @(posedge clk) begin
    if (wr_en && (mode_q == MODE_PUSH)) begin
      data_mem[slot_idx] <= val_q;
    end
    if (state == S_READ) begin
      data_rd <= data_mem[slot_b_idx];
    end
  end

  // Slot link memory. A push links the slot onto the old top, a pop links it
  // onto the free list.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[slot_idx] <= link_wdata;
    end
    if (state == S_READ) begin
      link_rd <= link_mem[slot_b_idx];
    end
  end

  // Stack head memory; its valid bits make unwritten heads read as null.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      head_mem[sid_idx] <= head_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
    end else if (wr_en) begin
      head_vld[sid_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      hwm       <= '0;
    end else if (wr_en) begin
      if (mode_q == MODE_PUSH) begin
        free_head <= link_val;
        if (virt_q) begin
          hwm <= slot_inc;
        end
      end else begin
        free_head <= slot_q;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tuser <= st_q;
      m_tdata <= ((mode_q == MODE_POP) && (st_q == ST_DONE)) ?
                 OUT_TDATA_W'(data_rd) : '0;
    end
  end

  `MSSP_ASSERT_NEXT(a_accept_reads, clk, rst, accept, state == S_READ)
  `MSSP_ASSERT_NEXT(a_read_writes, clk, rst, state == S_READ, state == S_WRITE)
  `MSSP_ASSERT_NOW(a_free_head_range, clk, rst, 1'b1, free_head <= LINK_NULL)
  `MSSP_ASSERT_NOW(a_fill_mark_range, clk, rst, 1'b1, hwm <= LINK_NULL)
  `MSSP_ASSERT_NOW(a_value_only_on_pop, clk, rst, m_tvalid && (m_tuser != ST_DONE), m_tdata == '0)

endmodule
